@@ hw/rtl/sdcs_pkg.sv @@
package sdcs_pkg;

   // Operation codes of an event.
   localparam logic [2:0] OP_START     = 3'd0;
   localparam logic [2:0] OP_CMD_DONE  = 3'd1;
   localparam logic [2:0] OP_READ      = 3'd2;
   localparam logic [2:0] OP_WRITE     = 3'd3;
   localparam logic [2:0] OP_DATA_DONE = 3'd4;

   // Result kinds.
   localparam logic [2:0] KIND_ISSUE  = 3'd0;
   localparam logic [2:0] KIND_AWAIT  = 3'd1;
   localparam logic [2:0] KIND_DONE   = 3'd2;
   localparam logic [2:0] KIND_FAIL   = 3'd3;
   localparam logic [2:0] KIND_REJECT = 3'd4;

   // Configuration register indexes.
   localparam logic CSR_SECTOR_LIMIT = 1'b0;
   localparam logic CSR_RETRY_LIMIT  = 1'b1;

   localparam logic [31:0] SECTOR_LIMIT_RESET = 32'd262144;
   localparam logic [15:0] RETRY_LIMIT_RESET  = 16'd1000;
   localparam int unsigned SECTOR_BYTES_DEFAULT = 512;

   // SD command indexes.
   localparam logic [5:0] CMD_GO_IDLE   = 6'd0;
   localparam logic [5:0] CMD_ALL_CID   = 6'd2;
   localparam logic [5:0] CMD_SEND_RCA  = 6'd3;
   localparam logic [5:0] CMD_SELECT    = 6'd7;
   localparam logic [5:0] CMD_IF_COND   = 6'd8;
   localparam logic [5:0] CMD_BLOCKLEN  = 6'd16;
   localparam logic [5:0] CMD_READ_BLK  = 6'd17;
   localparam logic [5:0] CMD_WRITE_BLK = 6'd24;
   localparam logic [5:0] CMD_OP_COND   = 6'd41;
   localparam logic [5:0] CMD_APP       = 6'd55;

   // Command word flags.
   localparam logic [31:0] FLAG_R136      = 32'h0001_0000;
   localparam logic [31:0] FLAG_R48       = 32'h0002_0000;
   localparam logic [31:0] FLAG_R48B      = 32'h0003_0000;
   localparam logic [31:0] FLAG_CRC       = 32'h0008_0000;
   localparam logic [31:0] FLAG_IDX       = 32'h0010_0000;
   localparam logic [31:0] FLAG_DATA      = 32'h0020_0000;
   localparam logic [31:0] FLAG_BLKCNT    = 32'h0000_0002;
   localparam logic [31:0] FLAG_TO_HOST   = 32'h0000_0010;
   localparam logic [31:0] FLAGS_STD      = FLAG_R48 | FLAG_CRC | FLAG_IDX;
   localparam logic [31:0] FLAGS_TRANSFER = FLAGS_STD | FLAG_DATA | FLAG_BLKCNT;

   localparam logic [31:0] OPCOND_ARG = 32'h40FF_8000;
   localparam logic [11:0] ECHO_CHECK = 12'h1AA;
   localparam logic [31:0] ECHO_ARG   = 32'h0000_01AA;

   typedef struct packed {
      logic [2:0]  kind;
      logic [31:0] word;
      logic [31:0] arg;
      logic        ready;
      logic        high_capacity;
      logic [15:0] rca;
   } sdcs_result_type;

   function automatic logic [31:0] cmd_word(input logic [5:0] index, input logic [31:0] flags);
      return {2'b00, index, 24'h00_0000} | flags;
   endfunction

endpackage

@@ hw/rtl/sdcs_sequencer.sv @@
module sdcs_sequencer #(
   parameter int unsigned SectorBytes = sdcs_pkg::SECTOR_BYTES_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      step_en,
   input  logic [2:0]                operation,
   input  logic                      completion_ok,
   input  logic [31:0]               response_word,
   input  logic [31:0]               sector_address,
   input  logic [31:0]               sector_limit,
   input  logic [15:0]               retry_limit,
   output sdcs_pkg::sdcs_result_type result
);
   import sdcs_pkg::*;

   typedef enum logic [3:0] {
      PH_IDLE,
      PH_GO_IDLE,
      PH_IF_COND,
      PH_APP,
      PH_OP_COND,
      PH_CID,
      PH_RCA,
      PH_SELECT,
      PH_BLOCKLEN,
      PH_RD_CMD,
      PH_WR_CMD,
      PH_RD_DATA,
      PH_WR_DATA
   } phase_type;

   localparam logic [31:0] SectorBytesWord = 32'(SectorBytes);

   phase_type   phase_ff, phase_in;
   logic [15:0] retry_ff, retry_in;
   logic [15:0] rca_ff, rca_in;
   logic        hc_ff, hc_in;
   logic        ready_ff, ready_in;

   logic [2:0]  kind;
   logic [31:0] word;
   logic [31:0] arg;
   logic [15:0] retry_next;
   logic [31:0] byte_address;
   logic        cmd_pending;

   assign retry_next   = (retry_ff == 16'hFFFF) ? retry_ff : retry_ff + 16'd1;
   assign byte_address = sector_address * SectorBytesWord;
   assign cmd_pending  = (phase_ff != PH_IDLE) && (phase_ff != PH_RD_DATA) &&
                         (phase_ff != PH_WR_DATA);

   always_comb begin
      phase_in = phase_ff;
      retry_in = retry_ff;
      rca_in   = rca_ff;
      hc_in    = hc_ff;
      ready_in = ready_ff;
      kind     = KIND_REJECT;
      word     = 32'h0;
      arg      = 32'h0;
      case (operation)
         OP_START: begin
            if (phase_ff == PH_IDLE) begin
               ready_in = 1'b0;
               hc_in    = 1'b0;
               rca_in   = 16'h0;
               retry_in = 16'h0;
               kind     = KIND_ISSUE;
               word     = cmd_word(CMD_GO_IDLE, 32'h0);
               phase_in = PH_GO_IDLE;
            end
         end
         OP_CMD_DONE: begin
            if (cmd_pending) begin
               if (!completion_ok) begin
                  kind     = KIND_FAIL;
                  phase_in = PH_IDLE;
               end else begin
                  kind = KIND_ISSUE;
                  case (phase_ff)
                     PH_GO_IDLE: begin
                        word     = cmd_word(CMD_IF_COND, FLAGS_STD);
                        arg      = ECHO_ARG;
                        phase_in = PH_IF_COND;
                     end
                     PH_IF_COND: begin
                        if (response_word[11:0] != ECHO_CHECK) begin
                           kind     = KIND_FAIL;
                           phase_in = PH_IDLE;
                        end else begin
                           retry_in = 16'h0;
                           word     = cmd_word(CMD_APP, FLAGS_STD);
                           arg      = {rca_ff, 16'h0};
                           phase_in = PH_APP;
                        end
                     end
                     PH_APP: begin
                        word     = cmd_word(CMD_OP_COND, FLAG_R48);
                        arg      = OPCOND_ARG;
                        phase_in = PH_OP_COND;
                     end
                     PH_OP_COND: begin
                        retry_in = retry_next;
                        if (response_word[31]) begin
                           hc_in    = response_word[30];
                           word     = cmd_word(CMD_ALL_CID, FLAG_R136 | FLAG_CRC);
                           phase_in = PH_CID;
                        end else if (retry_next >= retry_limit) begin
                           kind     = KIND_FAIL;
                           phase_in = PH_IDLE;
                        end else begin
                           word     = cmd_word(CMD_APP, FLAGS_STD);
                           arg      = {rca_ff, 16'h0};
                           phase_in = PH_APP;
                        end
                     end
                     PH_CID: begin
                        word     = cmd_word(CMD_SEND_RCA, FLAGS_STD);
                        phase_in = PH_RCA;
                     end
                     PH_RCA: begin
                        rca_in = response_word[31:16];
                        if (response_word[31:16] == 16'h0) begin
                           kind     = KIND_FAIL;
                           phase_in = PH_IDLE;
                        end else begin
                           word     = cmd_word(CMD_SELECT, FLAG_R48B | FLAG_CRC | FLAG_IDX);
                           arg      = {response_word[31:16], 16'h0};
                           phase_in = PH_SELECT;
                        end
                     end
                     PH_SELECT: begin
                        word     = cmd_word(CMD_BLOCKLEN, FLAGS_STD);
                        arg      = SectorBytesWord;
                        phase_in = PH_BLOCKLEN;
                     end
                     PH_BLOCKLEN: begin
                        ready_in = 1'b1;
                        kind     = KIND_DONE;
                        phase_in = PH_IDLE;
                     end
                     PH_RD_CMD: begin
                        kind     = KIND_AWAIT;
                        phase_in = PH_RD_DATA;
                     end
                     default: begin
                        kind     = KIND_AWAIT;
                        phase_in = PH_WR_DATA;
                     end
                  endcase
               end
            end
         end
         OP_READ, OP_WRITE: begin
            if (phase_ff == PH_IDLE) begin
               if (!ready_ff || (sector_address >= sector_limit)) begin
                  kind = KIND_FAIL;
               end else begin
                  kind = KIND_ISSUE;
                  arg  = hc_ff ? sector_address : byte_address;
                  if (operation == OP_READ) begin
                     word     = cmd_word(CMD_READ_BLK, FLAGS_TRANSFER | FLAG_TO_HOST);
                     phase_in = PH_RD_CMD;
                  end else begin
                     word     = cmd_word(CMD_WRITE_BLK, FLAGS_TRANSFER);
                     phase_in = PH_WR_CMD;
                  end
               end
            end
         end
         OP_DATA_DONE: begin
            if ((phase_ff == PH_RD_DATA) || (phase_ff == PH_WR_DATA)) begin
               kind     = completion_ok ? KIND_DONE : KIND_FAIL;
               phase_in = PH_IDLE;
            end
         end
         default: begin
            kind = KIND_REJECT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         retry_ff <= 16'h0;
         rca_ff   <= 16'h0;
         hc_ff    <= 1'b0;
         ready_ff <= 1'b0;
      end else if (step_en) begin
         phase_ff <= phase_in;
         retry_ff <= retry_in;
         rca_ff   <= rca_in;
         hc_ff    <= hc_in;
         ready_ff <= ready_in;
      end
   end

   assign result = '{kind: kind, word: word, arg: arg, ready: ready_in,
                     high_capacity: hc_in, rca: rca_in};

endmodule

@@ hw/rtl/sd_card_command_sequencer_unit.sv @@
// SD card command sequencer. Each transfer on the req_ channel is one event (start init,
// command done, read or write sector, data done) and produces exactly one transfer on the
// rsp_ channel: the next command word and argument, await data, finished, failed or
// rejected, together with the card status after the event. An accepted event's result is
// registered; a new event can be accepted every cycle while req_stall is low. The result
// register is backed by one skid entry, so req_stall rises only when both hold results
// that the consumer has not taken. Configuration writes must happen while no event is
// outstanding.
module sd_card_command_sequencer_unit #(
   parameter int unsigned SectorBytes = sdcs_pkg::SECTOR_BYTES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_operation,
   input  logic        req_completion_ok,
   input  logic [31:0] req_response_word,
   input  logic [31:0] req_sector_address,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_result_kind,
   output logic [31:0] rsp_command_word,
   output logic [31:0] rsp_command_argument,
   output logic        rsp_card_ready,
   output logic        rsp_high_capacity,
   output logic [15:0] rsp_card_address,
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [31:0] csr_write_data
);
   import sdcs_pkg::*;

   logic [31:0]     sector_limit_ff;
   logic [15:0]     retry_limit_ff;
   sdcs_result_type step_result;
   sdcs_result_type out_ff, out_in;
   sdcs_result_type skid_ff, skid_in;
   logic            out_valid_ff, out_valid_in;
   logic            skid_valid_ff, skid_valid_in;
   logic            accept;
   logic            out_take;

   assign accept   = req_valid && !skid_valid_ff;
   assign out_take = out_valid_ff && !rsp_stall;

   sdcs_sequencer #(
      .SectorBytes(SectorBytes)
   ) u_sequencer (
      .clock         (clock),
      .reset         (reset),
      .step_en       (accept),
      .operation     (req_operation),
      .completion_ok (req_completion_ok),
      .response_word (req_response_word),
      .sector_address(req_sector_address),
      .sector_limit  (sector_limit_ff),
      .retry_limit   (retry_limit_ff),
      .result        (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         sector_limit_ff <= SECTOR_LIMIT_RESET;
         retry_limit_ff  <= RETRY_LIMIT_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_SECTOR_LIMIT: sector_limit_ff <= csr_write_data;
            CSR_RETRY_LIMIT:  retry_limit_ff  <= csr_write_data[15:0];
            default:          sector_limit_ff <= sector_limit_ff;
         endcase
      end
   end

   // The skid entry always holds a younger result than the output register.
   always_comb begin
      out_in        = out_ff;
      skid_in       = skid_ff;
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         if (out_take) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (accept) begin
         if (!out_valid_ff || out_take) begin
            out_in       = step_result;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = step_result;
            skid_valid_in = 1'b1;
         end
      end else if (out_take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign req_stall            = skid_valid_ff;
   assign rsp_valid            = out_valid_ff;
   assign rsp_result_kind      = out_ff.kind;
   assign rsp_command_word     = out_ff.word;
   assign rsp_command_argument = out_ff.arg;
   assign rsp_card_ready       = out_ff.ready;
   assign rsp_high_capacity    = out_ff.high_capacity;
   assign rsp_card_address     = out_ff.rca;

   a_skid_behind_output: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry holds a result while the output register is empty");

   a_quiet_command_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_result_kind != KIND_ISSUE)) |->
         ((rsp_command_word == 32'h0) && (rsp_command_argument == 32'h0)))
      else $error("command fields set on a result that issues no command");

   a_ready_has_address: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_card_ready) |-> (rsp_card_address != 16'h0))
      else $error("card reported ready without a card address");

endmodule
